@@ design/cdps_pkg.sv @@
`default_nettype none

package cdps_pkg;

   localparam int MAX_PRESCALE      = 255;
   localparam int MAX_DIVIDER_INDEX = 255;

   localparam int SRC_W   = 27;
   localparam int TGT_W   = 26;
   localparam int TOL_W   = 7;
   localparam int PRE_W   = 8;
   localparam int IDX_W   = 8;
   localparam int SCALE_W = 8;
   localparam int LIM_W   = TGT_W + SCALE_W;
   // target/100 stays below 2**20 for any 26-bit target
   localparam int Q_W     = 20;

   // largest even prescaler that the sweep reaches
   localparam int LAST_PRESCALE = MAX_PRESCALE - (MAX_PRESCALE % 2);
   localparam int DIVISOR_MAX   = LAST_PRESCALE * (MAX_DIVIDER_INDEX + 1);
   localparam int DIVISOR_BITS  = $clog2(DIVISOR_MAX + 1);
   // the divisor port also carries the constant 100
   localparam int DIVISOR_W     = (DIVISOR_BITS > 7) ? DIVISOR_BITS : 7;

   localparam int PERCENT = 100;

   localparam logic             MODE_BEST_FIT  = 1'b0;
   localparam logic             MODE_FIRST_FIT = 1'b1;
   localparam logic [TOL_W-1:0] TOL_RESET      = TOL_W'(5);

   localparam int CSR_W = TOL_W;

   typedef enum logic [0:0] {
      CSR_SEARCH_MODE = 1'b0,
      CSR_TOLERANCE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SRC_W-1:0] source_clock;
      logic [TGT_W-1:0] wanted_clock;
   } req_type;

   typedef struct packed {
      logic [PRE_W-1:0] prescale_value;
      logic [IDX_W-1:0] divider_minus_one;
      logic [SRC_W-1:0] achieved_clock;
      logic             found;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [SRC_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SRC_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

@@ design/cdps_serial_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module cdps_serial_div import cdps_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int                STEP_W    = $clog2(SRC_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SRC_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SRC_W-1:0]     dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] den_ff, den_in;

   logic [DIVISOR_W:0]   rem_shift;
   logic [DIVISOR_W:0]   rem_diff;
   logic                 fits;

   assign rem_shift = {rem_ff, dvd_ff[SRC_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = (rem_shift >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         dvd_in  = {dvd_ff[SRC_W-2:0], fits};
         rem_in  = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

`default_nettype wire

@@ design/clock_divider_pair_search_unit.sv @@
// Forms target/100 on the 27-step bit-serial divider, then tries one
// (prescaler, divider) pair per division, then loads the result register; a
// full sweep covers 127 prescalers by 256 dividers. One request at a time; the
// next is taken once the result register is loaded. Synchronous active-high
// reset returns to idle, drops any pending result and loads search_mode 0,
// tolerance_percent 5.
`default_nettype none

module clock_divider_pair_search_unit import cdps_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   // result channel
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data,
   // configuration writes
   input  wire logic          csr_write,
   input  wire csr_index_type csr_index,
   input  wire logic [CSR_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QWAIT,
      ST_START,
      ST_DWAIT,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   localparam logic [DIVISOR_W-1:0] PCT_DIVISOR = DIVISOR_W'(PERCENT);
   localparam logic [PRE_W-1:0]     FIRST_PRE   = PRE_W'(2);
   localparam logic [PRE_W-1:0]     LAST_PRE    = PRE_W'(LAST_PRESCALE);
   localparam logic [IDX_W-1:0]     LAST_IDX    = IDX_W'(MAX_DIVIDER_INDEX);

   // control state
   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             mode_ff, mode_in;
   logic [TOL_W-1:0] tol_ff, tol_in;

   // working registers of the current request
   logic [SRC_W-1:0]     src_ff, src_in;
   logic [TGT_W-1:0]     tgt_ff, tgt_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [LIM_W-1:0]     lim_ff, lim_in;
   logic [LIM_W-1:0]     maxclk_ff, maxclk_in;
   logic [PRE_W-1:0]     p_ff, p_in;
   logic [IDX_W-1:0]     d_ff, d_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [SRC_W-1:0]     clk_ff, clk_in;
   logic [LIM_W-1:0]     clk100_ff, clk100_in;
   logic                 below_ff, below_in;
   logic [SRC_W-1:0]     diff_ff, diff_in;
   logic [SRC_W-1:0]     closest_gap_ff, closest_gap_in;
   logic                 have_ff, have_in;
   logic [PRE_W-1:0]     bp_ff, bp_in;
   logic [IDX_W-1:0]     bd_ff, bd_in;
   logic [SRC_W-1:0]     bclk_ff, bclk_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic [SCALE_W-1:0]   scale_now;
   logic [SRC_W-1:0]     tgt_wide;
   logic                 slot_free;
   logic                 hit_first;
   logic                 better;
   logic                 last_d;
   logic                 last_p;
   logic [PRE_W-1:0]     p_next;

   cdps_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign scale_now = SCALE_W'(PERCENT) + SCALE_W'(tol_ff);
   assign tgt_wide  = SRC_W'(tgt_ff);
   // the result register takes a new value once the old one is gone
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign last_d    = (d_ff == LAST_IDX);
   assign last_p    = (p_ff == LAST_PRE);
   assign p_next    = p_ff + PRE_W'(2);
   assign hit_first = (mode_ff == MODE_FIRST_FIT) && (clk100_ff <= lim_ff);
   assign better    = (mode_ff == MODE_BEST_FIT) && below_ff && (diff_ff < closest_gap_ff);

   // Configuration writes; host must wait till no request is in flight; unchecked.
   always_comb begin
      mode_in = mode_ff;
      tol_in  = tol_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SEARCH_MODE: mode_in = csr_data[0];
            CSR_TOLERANCE:   tol_in  = csr_data[TOL_W-1:0];
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      src_in         = src_ff;
      tgt_in         = tgt_ff;
      scale_in       = scale_ff;
      lim_in         = lim_ff;
      maxclk_in      = maxclk_ff;
      p_in           = p_ff;
      d_in           = d_ff;
      divisor_in     = divisor_ff;
      clk_in         = clk_ff;
      clk100_in      = clk100_ff;
      below_in       = below_ff;
      diff_in        = diff_ff;
      closest_gap_in = closest_gap_ff;
      have_in        = have_ff;
      bp_in          = bp_ff;
      bd_in          = bd_ff;
      bclk_in        = bclk_ff;

      // drop the pending result once it is transferred
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      div_req.start    = 1'b0;
      div_req.dividend = src_ff;
      div_req.divisor  = divisor_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // latch the request and start target/100 on the shared divider
               src_in           = req_data.source_clock;
               tgt_in           = req_data.wanted_clock;
               scale_in         = scale_now;
               lim_in           = LIM_W'(req_data.wanted_clock) * LIM_W'(scale_now);
               closest_gap_in   = SRC_W'(req_data.wanted_clock) + SRC_W'(1);
               have_in          = 1'b0;
               bp_in            = '0;
               bd_in            = '0;
               bclk_in          = '0;
               p_in             = FIRST_PRE;
               d_in             = '0;
               divisor_in       = DIVISOR_W'(FIRST_PRE);
               div_req.start    = 1'b1;
               div_req.dividend = SRC_W'(req_data.wanted_clock);
               div_req.divisor  = PCT_DIVISOR;
               state_in         = ST_QWAIT;
            end
         end
         ST_QWAIT: begin
            if (div_rsp.done) begin
               // best-fit ceiling: (target/100) * (100 + tolerance)
               maxclk_in = LIM_W'(div_rsp.quotient[Q_W-1:0]) * LIM_W'(scale_ff);
               state_in  = ST_START;
            end
         end
         ST_START: begin
            div_req.start = 1'b1;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_rsp.done) begin
               clk_in    = div_rsp.quotient;
               clk100_in = LIM_W'(div_rsp.quotient) * LIM_W'(PERCENT);
               below_in  = LIM_W'(div_rsp.quotient) < maxclk_ff;
               diff_in   = (div_rsp.quotient >= tgt_wide) ? div_rsp.quotient - tgt_wide
                                                         : tgt_wide - div_rsp.quotient;
               state_in  = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (hit_first || better) begin
               have_in = 1'b1;
               bp_in   = p_ff;
               bd_in   = d_ff;
               bclk_in = clk_ff;
            end
            if (better) begin
               closest_gap_in = diff_ff;
            end
            priority if (hit_first || (better && diff_ff == '0)) begin
               state_in = ST_FINISH;
            end else if (last_d && last_p) begin
               state_in = ST_FINISH;
            end else if (last_d) begin
               // advance to the next even prescaler, divider back to one
               p_in       = p_next;
               d_in       = '0;
               divisor_in = DIVISOR_W'(p_next);
               state_in   = ST_START;
            end else begin
               d_in       = d_ff + IDX_W'(1);
               divisor_in = divisor_ff + DIVISOR_W'(p_ff);
               state_in   = ST_START;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.prescale_value    = bp_ff;
               rsp_data_in.divider_minus_one = bd_ff;
               rsp_data_in.achieved_clock    = bclk_ff;
               rsp_data_in.found             = have_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_BEST_FIT;
         tol_ff       <= TOL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         tol_ff       <= tol_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      tgt_ff         <= tgt_in;
      scale_ff       <= scale_in;
      lim_ff         <= lim_in;
      maxclk_ff      <= maxclk_in;
      p_ff           <= p_in;
      d_ff           <= d_in;
      divisor_ff     <= divisor_in;
      clk_ff         <= clk_in;
      clk100_ff      <= clk100_in;
      below_ff       <= below_in;
      diff_ff        <= diff_in;
      closest_gap_ff <= closest_gap_in;
      have_ff        <= have_in;
      bp_ff          <= bp_in;
      bd_ff          <= bd_in;
      bclk_ff        <= bclk_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_QWAIT || state_ff == ST_DWAIT))
      else $error("divider done outside a wait state");

   // In the start state the running divisor equals prescaler times divider.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |->
         (divisor_ff == DIVISOR_W'(p_ff) * (DIVISOR_W'(d_ff) + DIVISOR_W'(1))))
      else $error("divisor out of step with prescaler and divider");

   // A new result appears only from the finish state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finish state");

   // A found pair carries a nonzero even prescaler.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.found) |->
         (rsp_data_ff.prescale_value != '0 && !rsp_data_ff.prescale_value[0]))
      else $error("found result with an invalid prescaler");

endmodule

`default_nettype wire

@@ verif/clock_divider_pair_search_unit_test.sv @@
`default_nettype none

module clock_divider_pair_search_unit_test;
   import cdps_pkg::*;

   localparam int unsigned SRC_TOP = (1 << SRC_W) - 1;
   localparam int unsigned TGT_TOP = (1 << TGT_W) - 1;
   localparam int          NUM_DIRECTED = 19;

   // One directed transfer: the settings it runs under, the request, and an
   // optional hand-written result. Rows without one go through the predictor.
   typedef struct {
      logic        mode;
      int unsigned tol;
      int unsigned src;
      int unsigned tgt;
      bit          typed;
      int unsigned pre;
      int unsigned idx;
      int unsigned clk;
      bit          found;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_write;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_data;

   // settings as the block holds them; changed only while it is idle
   logic             mode_setting = MODE_BEST_FIT;
   logic [TOL_W-1:0] tol_setting  = TOL_RESET;

   // divider pairs still owed by the block, oldest first
   rsp_type pending_pairs[$];
   int      mismatch_count = 0;

   // idle percentages and the long receiver hold-off; written at a rising edge,
   // read at a falling edge
   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int hold_off_left = 0;

   // Rows: best-fit cases first (reset settings, exact matches at various
   // depths, zero target where nothing qualifies), then first-fit cases
   // (zero source, tolerance zero, at 100 and above 100, limit hit exactly,
   // search spilling into the second prescaler).
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{MODE_BEST_FIT,    5, 134217727, 67108863, 1, 2, 0, 67108863, 1},
      '{MODE_BEST_FIT,    5,      1000,      500, 1, 2, 0,      500, 1},
      '{MODE_BEST_FIT,    5,   1000000,     1000, 0, 0, 0,        0, 0},
      '{MODE_BEST_FIT,    5,     30000,     5000, 0, 0, 0,        0, 0},
      '{MODE_BEST_FIT,    5,   5000000,        0, 1, 0, 0,        0, 0},
      '{MODE_BEST_FIT,    1,     20000,    10000, 1, 2, 0,    10000, 1},
      '{MODE_BEST_FIT,    1, 134217727,   335544, 0, 0, 0,        0, 0},
      '{MODE_BEST_FIT,  127,       600,      300, 1, 2, 0,      300, 1},
      '{MODE_BEST_FIT,  100,  67108863,  3355443, 0, 0, 0,        0, 0},
      '{MODE_FIRST_FIT,   5,         0,        0, 1, 2, 0,        0, 1},
      '{MODE_FIRST_FIT,   5,         0, 67108863, 1, 2, 0,        0, 1},
      '{MODE_FIRST_FIT,   5, 134217727, 67108863, 1, 2, 0, 67108863, 1},
      '{MODE_FIRST_FIT,   5,    100000,      150, 0, 0, 0,        0, 0},
      '{MODE_FIRST_FIT,   0,      1000,      500, 1, 2, 0,      500, 1},
      '{MODE_FIRST_FIT,   0,      1000,      499, 1, 2, 1,      250, 1},
      '{MODE_FIRST_FIT, 100,      1000,      250, 1, 2, 0,      500, 1},
      '{MODE_FIRST_FIT, 100,      1000,      249, 1, 2, 1,      250, 1},
      '{MODE_FIRST_FIT, 127,      1000,      250, 1, 2, 0,      500, 1},
      '{MODE_FIRST_FIT, 127,      2000,        1, 0, 0, 0,        0, 0}
   };

   clock_divider_pair_search_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Sweep even prescalers, then divider indices, in the block's order and
   // return the pair it should settle on under the current settings.
   function automatic rsp_type search_divider_pair(input req_type item);
      longint unsigned src, tgt, scale, ceiling, clk, diff, closest_gap;
      rsp_type pick;
      src   = item.source_clock;
      tgt   = item.wanted_clock;
      scale = PERCENT + tol_setting;
      pick  = '0;
      if (mode_setting == MODE_FIRST_FIT) begin
         // first pair whose clock stays within the tolerance
         for (int p = 2; p <= MAX_PRESCALE; p += 2) begin
            for (int d = 0; d <= MAX_DIVIDER_INDEX; d++) begin
               clk = src / (p * (d + 1));
               if (clk * PERCENT <= tgt * scale) begin
                  pick.prescale_value    = PRE_W'(p);
                  pick.divider_minus_one = IDX_W'(d);
                  pick.achieved_clock    = SRC_W'(clk);
                  pick.found             = 1'b1;
                  return pick;
               end
            end
         end
         return pick;
      end
      // best fit: closest clock strictly under the truncated ceiling;
      // earliest pair wins a tie, an exact hit ends the sweep
      ceiling     = (tgt / PERCENT) * scale;
      closest_gap = tgt + 1;
      for (int p = 2; p <= MAX_PRESCALE; p += 2) begin
         for (int d = 0; d <= MAX_DIVIDER_INDEX; d++) begin
            clk = src / (p * (d + 1));
            if (clk < ceiling) begin
               diff = (clk >= tgt) ? clk - tgt : tgt - clk;
               if (diff < closest_gap) begin
                  closest_gap            = diff;
                  pick.prescale_value    = PRE_W'(p);
                  pick.divider_minus_one = IDX_W'(d);
                  pick.achieved_clock    = SRC_W'(clk);
                  pick.found             = 1'b1;
                  if (diff == 0)
                     return pick;
               end
            end
         end
      end
      return pick;
   endfunction

   // Best-fit request with an exact match planted at the first prescaler, so
   // the sweep ends early. A target whose remainder mod 100 would push it past
   // the truncated ceiling is rounded down to a multiple of 100.
   function automatic req_type best_fit_item();
      int unsigned span, top, tgt;
      req_type item;
      span = 2 * (($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                              : $urandom_range(1, 32));
      top  = (SRC_TOP - (span - 1)) / span;
      if (top > TGT_TOP)
         top = TGT_TOP;
      tgt = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 20000)
                                        : $urandom_range(100, top);
      if (tgt % PERCENT >= (tgt / PERCENT) * tol_setting)
         tgt -= tgt % PERCENT;
      item.wanted_clock = TGT_W'(tgt);
      item.source_clock = SRC_W'(tgt * span + $urandom_range(0, span - 1));
      return item;
   endfunction

   // First-fit request that qualifies within the first two prescalers: either
   // a target near source/(2k), or a random target floored at source/1024.
   function automatic req_type first_fit_item();
      longint unsigned src, tgt, k;
      req_type item;
      src = $urandom_range(0, SRC_TOP);
      if ($urandom_range(0, 4) == 0) begin
         tgt = $urandom_range(0, TGT_TOP);
         if (tgt < (src >> 10))
            tgt = src >> 10;
      end else begin
         k   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 64);
         tgt = src / (2 * k) + $urandom_range(0, 1000);
         if (tgt > TGT_TOP)
            tgt = TGT_TOP;
      end
      item.source_clock = SRC_W'(src);
      item.wanted_clock = TGT_W'(tgt);
      return item;
   endfunction

   // Offer one request, holding it until the block takes the transfer, and
   // queue the pair it owes. Enter and leave at a falling edge.
   task automatic offer_transfer(input req_type item, input bit typed,
                                 input rsp_type typed_pair);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_pairs.push_back(typed ? typed_pair : search_divider_pair(item));
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed pair has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_pairs.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_gap_pct = send_pct;
      recv_gap_pct = recv_pct;
      @(negedge clock);
   endtask

   // Write both registers on back-to-back edges; only called while idle.
   task automatic apply_settings(input logic mode, input logic [TOL_W-1:0] tol);
      csr_write <= 1'b1;
      csr_index <= CSR_SEARCH_MODE;
      csr_data  <= CSR_W'(mode);
      @(negedge clock);
      csr_index <= CSR_TOLERANCE;
      csr_data  <= tol;
      @(negedge clock);
      csr_write    <= 1'b0;
      mode_setting = mode;
      tol_setting  = tol;
   endtask

   // Stimulus: directed table, then random phases with shifting idle patterns.
   initial begin : drive_requests
      req_type item;
      rsp_type typed_pair;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_index = CSR_SEARCH_MODE;
      csr_data  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender idles lightly, receiver heavily
      set_idling(20, 60);

      // Walk the table; reconfigure only between rows whose settings differ,
      // after the block has returned everything it owes.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].mode != mode_setting || directed_rows[i].tol != tol_setting) begin
            hold_until_drained();
            apply_settings(directed_rows[i].mode, TOL_W'(directed_rows[i].tol));
         end
         item.source_clock            = SRC_W'(directed_rows[i].src);
         item.wanted_clock            = TGT_W'(directed_rows[i].tgt);
         typed_pair.prescale_value    = PRE_W'(directed_rows[i].pre);
         typed_pair.divider_minus_one = IDX_W'(directed_rows[i].idx);
         typed_pair.achieved_clock    = SRC_W'(directed_rows[i].clk);
         typed_pair.found             = directed_rows[i].found;
         offer_transfer(item, directed_rows[i].typed, typed_pair);
      end

      // first fit, random tolerance including zero
      hold_until_drained();
      apply_settings(MODE_FIRST_FIT, TOL_W'($urandom_range(0, 127)));
      repeat (30) offer_transfer(first_fit_item(), 1'b0, '0);

      // best fit, idling swapped; a zero tolerance would make every
      // best-fit request sweep the full range, so keep it at one or more
      hold_until_drained();
      set_idling(60, 20);
      apply_settings(MODE_BEST_FIT, TOL_W'($urandom_range(1, 127)));
      repeat (30) offer_transfer(best_fit_item(), 1'b0, '0);

      // no idling; receiver holds off long enough for two full requests, so
      // the block fills up and stalls its request side while requests keep coming
      hold_until_drained();
      set_idling(0, 0);
      apply_settings(MODE_BEST_FIT, TOL_W'($urandom_range(1, 127)));
      @(posedge clock);
      hold_off_left = 20000;
      @(negedge clock);
      repeat (20) offer_transfer(best_fit_item(), 1'b0, '0);

      // top tolerance in first fit, still no idling
      hold_until_drained();
      apply_settings(MODE_FIRST_FIT, TOL_W'(127));
      repeat (20) offer_transfer(first_fit_item(), 1'b0, '0);

      hold_until_drained();
      repeat (60) @(negedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random stall per cycle, or a long hold-off counted down here.
   initial begin : drive_stall
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_stall <= 1'b1;
            hold_off_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_gap_pct);
         end
      end
   end

   // Compare each accepted result with the oldest owed pair, field by field.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pairs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_data.prescale_value != want.prescale_value) begin
               $display("%0t: prescale_value expected %0d actual %0d",
                        $time, want.prescale_value, rsp_data.prescale_value);
               mismatch_count++;
            end
            if (rsp_data.divider_minus_one != want.divider_minus_one) begin
               $display("%0t: divider_minus_one expected %0d actual %0d",
                        $time, want.divider_minus_one, rsp_data.divider_minus_one);
               mismatch_count++;
            end
            if (rsp_data.achieved_clock != want.achieved_clock) begin
               $display("%0t: achieved_clock expected %0d actual %0d",
                        $time, want.achieved_clock, rsp_data.achieved_clock);
               mismatch_count++;
            end
            if (rsp_data.found != want.found) begin
               $display("%0t: found expected %0d actual %0d",
                        $time, want.found, rsp_data.found);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: one request sweeps the full range and all other requests
   // end within two prescalers; allow many times the slowest correct run.
   initial begin : watchdog
      #(200_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
